/* sv/rair_pkg.sv */
// Shared types and constants for the ray / axis-aligned rectangle intersection block.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package rair_pkg;

   localparam int CFG_W      = 32;  // width of the coordinate registers
   localparam int CSR_ADDR_W = 3;
   localparam int AXIS_W     = 2;
   localparam int MAT_W      = 16;
   localparam int UV_BITS    = 16;
   localparam int UV_W       = UV_BITS + 1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PLANE_AXIS   = 3'd0,
      CSR_RECT_A_MIN   = 3'd1,
      CSR_RECT_A_MAX   = 3'd2,
      CSR_RECT_B_MIN   = 3'd3,
      CSR_RECT_B_MAX   = 3'd4,
      CSR_PLANE_OFFSET = 3'd5,
      CSR_MATERIAL_ID  = 3'd6
   } csr_index_type;

   typedef enum logic [AXIS_W-1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

endpackage

/* sv/ray_axis_rect_intersect_top.sv */
// Ray against one axis-aligned rectangle: one ray accepted per cycle, one result beat per ray.
// Two bit-serial pipelined dividers compute the hit distance, then u and v; throughput is one beat a cycle.
// The whole pipeline advances together and holds when a result waits on rsp_tready.
// Synchronous reset empties the pipeline and loads the register defaults (XY rectangle 0..1).
`timescale 1ns / 1ps

module ray_axis_rect_intersect_top
   import rair_pkg::*;
#(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16,
   localparam int IN_W   = 8 * COORD_WIDTH,
   localparam int OUT_W  = 4 * COORD_WIDTH + 2 * UV_W + MAT_W + 2,
   localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lower, t_upper
   input  logic [IN_W-1:0]       req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // hit, hit_distance, surf_u, surf_v, point_x, point_y, point_z, front_face, hit_material
   output logic [OUT_TW-1:0]     rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata
);

   localparam int CW     = COORD_WIDTH;
   localparam int XW     = (CW > CFG_W) ? CW : CFG_W;
   localparam int NUM_W  = XW + 1;
   localparam int TN_W   = NUM_W + FRAC_BITS;
   localparam int TQ_W   = TN_W + 1;
   localparam int PROD_W = 2 * CW;
   localparam int P_W    = PROD_W + 1;
   localparam int SPAN_W = CFG_W + 1;
   localparam int UN_W   = SPAN_W + UV_BITS;
   localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic [UV_W-1:0] UV_ONE = {1'b1, {UV_BITS{1'b0}}};

   typedef struct packed {
      logic                     miss;
      logic                     front;
      logic                     neg;
      logic signed [CW-1:0]     tlo;
      logic signed [CW-1:0]     thi;
      logic [2:0][CW-1:0]       o;
      logic [2:0][CW-1:0]       d;
   } t_pay_type;

   typedef struct packed {
      logic                     hit;
      logic                     front;
      logic                     za;
      logic                     zb;
      logic [CW-1:0]            t;
      logic [2:0][CW-1:0]       pt;
   } uv_pay_type;

   // Configuration registers
   logic [AXIS_W-1:0]        plane_axis_ff;
   logic signed [CFG_W-1:0]  rect_a_min_ff, rect_a_max_ff, rect_b_min_ff, rect_b_max_ff;
   logic signed [CFG_W-1:0]  plane_offset_ff;
   logic [MAT_W-1:0]         material_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_axis_ff   <= AXIS_Z;
         rect_a_min_ff   <= '0;
         rect_a_max_ff   <= CFG_W'(65536);
         rect_b_min_ff   <= '0;
         rect_b_max_ff   <= CFG_W'(65536);
         plane_offset_ff <= '0;
         material_id_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_PLANE_AXIS:   plane_axis_ff   <= csr_wdata[AXIS_W-1:0];
            CSR_RECT_A_MIN:   rect_a_min_ff   <= csr_wdata;
            CSR_RECT_A_MAX:   rect_a_max_ff   <= csr_wdata;
            CSR_RECT_B_MIN:   rect_b_min_ff   <= csr_wdata;
            CSR_RECT_B_MAX:   rect_b_max_ff   <= csr_wdata;
            CSR_PLANE_OFFSET: plane_offset_ff <= csr_wdata;
            CSR_MATERIAL_ID:  material_id_ff  <= csr_wdata[MAT_W-1:0];
            default: ;
         endcase
      end
   end

   // Every stage moves together; the output register decides.
   logic out_valid_ff;
   logic adv;
   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;

   // Stage 1: pick the normal axis and form the numerator
   logic [2:0][CW-1:0] in_o, in_d;
   logic signed [CW-1:0] on_sel, dn_sel;
   logic axis_bad;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         in_o[i] = req_tdata[i*CW +: CW];
         in_d[i] = req_tdata[(3+i)*CW +: CW];
      end
   end

   always_comb begin
      on_sel   = signed'(in_o[2]);
      dn_sel   = signed'(in_d[2]);
      axis_bad = 1'b0;
      case (axis_type'(plane_axis_ff))
         AXIS_X: begin
            on_sel = signed'(in_o[0]);
            dn_sel = signed'(in_d[0]);
         end
         AXIS_Y: begin
            on_sel = signed'(in_o[1]);
            dn_sel = signed'(in_d[1]);
         end
         AXIS_Z: ;
         default: axis_bad = 1'b1;
      endcase
   end

   logic                    v1_ff;
   logic [2:0][CW-1:0]      o1_ff, d1_ff;
   logic signed [CW-1:0]    tlo1_ff, thi1_ff, dn1_ff;
   logic signed [NUM_W-1:0] num1_ff;
   logic                    miss1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o1_ff    <= in_o;
         d1_ff    <= in_d;
         tlo1_ff  <= signed'(req_tdata[6*CW +: CW]);
         thi1_ff  <= signed'(req_tdata[7*CW +: CW]);
         dn1_ff   <= dn_sel;
         num1_ff  <= NUM_W'(plane_offset_ff) - NUM_W'(on_sel);
         miss1_ff <= axis_bad || (dn_sel == '0);
      end
   end

   // Stage 2: magnitudes into the hit distance divider
   logic              num_neg, dn_neg;
   logic [NUM_W-1:0]  num_mag;
   logic [CW-1:0]     dn_mag;
   t_pay_type         t_pay_in, t_pay_out;
   logic              tq_valid;
   logic [TN_W-1:0]   tq;

   always_comb begin
      num_neg = num1_ff[NUM_W-1];
      dn_neg  = dn1_ff[CW-1];
      num_mag = num_neg ? NUM_W'(-num1_ff) : NUM_W'(num1_ff);
      dn_mag  = dn_neg ? CW'(-dn1_ff) : CW'(dn1_ff);
      t_pay_in.miss  = miss1_ff;
      t_pay_in.front = dn_neg;
      t_pay_in.neg   = num_neg ^ dn_neg;
      t_pay_in.tlo   = tlo1_ff;
      t_pay_in.thi   = thi1_ff;
      t_pay_in.o     = o1_ff;
      t_pay_in.d     = d1_ff;
   end

   rair_div #(
      .NW    (TN_W),
      .DW    (CW),
      .LANES (1),
      .PW    ($bits(t_pay_type))
   ) u_t_div (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .in_valid    (v1_ff),
      .dividend_in ({num_mag, {FRAC_BITS{1'b0}}}),
      .divisor_in  (dn_mag),
      .payload_in  (t_pay_in),
      .out_valid   (tq_valid),
      .quotient    (tq),
      .payload_out (t_pay_out)
   );

   // Stage 3: signed t and window test; a t that passes fits CW bits.
   logic signed [TQ_W-1:0] t_full;
   logic                   t_ok;

   always_comb begin
      t_full = t_pay_out.neg ? -signed'({1'b0, tq}) : signed'({1'b0, tq});
      t_ok   = (t_full >= TQ_W'(t_pay_out.tlo)) && (t_full <= TQ_W'(t_pay_out.thi));
   end

   logic                 v3_ff, miss3_ff, front3_ff;
   logic signed [CW-1:0] t3_ff;
   logic [2:0][CW-1:0]   o3_ff, d3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= tq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t3_ff     <= t_full[CW-1:0];
         miss3_ff  <= t_pay_out.miss || !t_ok;
         front3_ff <= t_pay_out.front;
         o3_ff     <= t_pay_out.o;
         d3_ff     <= t_pay_out.d;
      end
   end

   // Stage 4: t * dir on all three axes
   logic                     v4_ff, miss4_ff, front4_ff;
   logic signed [CW-1:0]     t4_ff;
   logic [2:0][CW-1:0]       o4_ff;
   logic signed [PROD_W-1:0] prod4_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            prod4_ff[i] <= t3_ff * signed'(d3_ff[i]);
         end
         t4_ff     <= t3_ff;
         o4_ff     <= o3_ff;
         miss4_ff  <= miss3_ff;
         front4_ff <= front3_ff;
      end
   end

   // Stage 5: hit point, the arithmetic shift rounds towards minus infinity
   logic                  v5_ff, miss5_ff, front5_ff;
   logic signed [CW-1:0]  t5_ff;
   logic signed [P_W-1:0] p5_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            p5_ff[i] <= P_W'(signed'(o4_ff[i])) + P_W'(prod4_ff[i] >>> FRAC_BITS);
         end
         t5_ff     <= t4_ff;
         miss5_ff  <= miss4_ff;
         front5_ff <= front4_ff;
      end
   end

   // Stage 6: rectangle bounds, offsets into the rectangle and saturated point
   logic signed [P_W-1:0]    pa, pb, ca_full, cb_full;
   logic signed [SPAN_W-1:0] span_a, span_b;
   logic                     in_rect;
   logic [2:0][CW-1:0]       pt_sat;

   always_comb begin
      pa = p5_ff[0];
      pb = p5_ff[1];
      case (axis_type'(plane_axis_ff))
         AXIS_X: begin
            pa = p5_ff[1];
            pb = p5_ff[2];
         end
         AXIS_Y: begin
            pa = p5_ff[0];
            pb = p5_ff[2];
         end
         default: ;
      endcase
      in_rect = (pa >= P_W'(rect_a_min_ff)) && (pa <= P_W'(rect_a_max_ff)) &&
                (pb >= P_W'(rect_b_min_ff)) && (pb <= P_W'(rect_b_max_ff));
      ca_full = pa - P_W'(rect_a_min_ff);
      cb_full = pb - P_W'(rect_b_min_ff);
      span_a  = SPAN_W'(rect_a_max_ff) - SPAN_W'(rect_a_min_ff);
      span_b  = SPAN_W'(rect_b_max_ff) - SPAN_W'(rect_b_min_ff);
      for (int i = 0; i < 3; i++) begin
         if (p5_ff[i] > P_W'(C_MAX)) begin
            pt_sat[i] = C_MAX;
         end else if (p5_ff[i] < P_W'(C_MIN)) begin
            pt_sat[i] = C_MIN;
         end else begin
            pt_sat[i] = p5_ff[i][CW-1:0];
         end
      end
   end

   logic                  v6_ff;
   logic [SPAN_W-1:0]     ca6_ff, cb6_ff, sa6_ff, sb6_ff;
   uv_pay_type            uv_pay6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= v5_ff;
      end
   end

   // Inside the rectangle the offsets lie in 0..span, so they fit SPAN_W bits unsigned.
   always_ff @(posedge clock) begin
      if (adv) begin
         ca6_ff           <= ca_full[SPAN_W-1:0];
         cb6_ff           <= cb_full[SPAN_W-1:0];
         sa6_ff           <= span_a;
         sb6_ff           <= span_b;
         uv_pay6_ff.hit   <= !miss5_ff && in_rect;
         uv_pay6_ff.front <= front5_ff;
         uv_pay6_ff.za    <= (span_a == '0);
         uv_pay6_ff.zb    <= (span_b == '0);
         uv_pay6_ff.t     <= t5_ff;
         uv_pay6_ff.pt    <= pt_sat;
      end
   end

   // u and v divider, two lanes
   logic                     uv_valid;
   logic [1:0][UN_W-1:0]     uv_q;
   uv_pay_type               uv_pay_out;

   rair_div #(
      .NW    (UN_W),
      .DW    (SPAN_W),
      .LANES (2),
      .PW    ($bits(uv_pay_type))
   ) u_uv_div (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .in_valid    (v6_ff),
      .dividend_in ({{cb6_ff, {UV_BITS{1'b0}}}, {ca6_ff, {UV_BITS{1'b0}}}}),
      .divisor_in  ({sb6_ff, sa6_ff}),
      .payload_in  (uv_pay6_ff),
      .out_valid   (uv_valid),
      .quotient    (uv_q),
      .payload_out (uv_pay_out)
   );

   // Output register; a miss reports all fields as zero.
   logic                  out_hit_ff, out_front_ff;
   logic [CW-1:0]         out_t_ff;
   logic [UV_W-1:0]       out_u_ff, out_v_ff;
   logic [2:0][CW-1:0]    out_pt_ff;
   logic [MAT_W-1:0]      out_mat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= uv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (uv_pay_out.hit) begin
            out_hit_ff   <= 1'b1;
            out_front_ff <= uv_pay_out.front;
            out_t_ff     <= uv_pay_out.t;
            out_u_ff     <= uv_pay_out.za ? '0 : uv_q[0][UV_W-1:0];
            out_v_ff     <= uv_pay_out.zb ? '0 : uv_q[1][UV_W-1:0];
            out_pt_ff    <= uv_pay_out.pt;
            out_mat_ff   <= material_id_ff;
         end else begin
            out_hit_ff   <= 1'b0;
            out_front_ff <= 1'b0;
            out_t_ff     <= '0;
            out_u_ff     <= '0;
            out_v_ff     <= '0;
            out_pt_ff    <= '0;
            out_mat_ff   <= '0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = OUT_TW'({out_mat_ff, out_front_ff, out_pt_ff[2], out_pt_ff[1],
                                out_pt_ff[0], out_v_ff, out_u_ff, out_t_ff, out_hit_ff});

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_hit_ff |-> rsp_tdata[OUT_W-1:1] == '0)
      else $error("miss beat carries non-zero fields");

   a_uv_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_hit_ff |-> (out_u_ff <= UV_ONE) && (out_v_ff <= UV_ONE))
      else $error("surface coordinate above one");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !v1_ff)
      else $error("pipeline not empty after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !adv |=> v3_ff && $stable(t3_ff))
      else $error("pipeline stage moved during a stall");

endmodule

/* sv/rair_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// Divides LANES pairs in parallel and carries a sideband payload alongside. No dependencies.
`timescale 1ns / 1ps

module rair_div #(
   parameter int NW    = 49,
   parameter int DW    = 32,
   parameter int LANES = 1,
   parameter int PW    = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [LANES-1:0][NW-1:0]    dividend_in,
   input  logic [LANES-1:0][DW-1:0]    divisor_in,
   input  logic [PW-1:0]               payload_in,
   output logic                        out_valid,
   output logic [LANES-1:0][NW-1:0]    quotient,
   output logic [PW-1:0]               payload_out
);

   logic [NW-1:0]                  valid_ff;
   logic [LANES-1:0][DW-1:0]       rem_ff  [NW];
   logic [LANES-1:0][NW-1:0]       work_ff [NW];
   logic [LANES-1:0][DW-1:0]       div_ff  [NW];
   logic [PW-1:0]                  pay_ff  [NW];

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic [LANES-1:0][DW-1:0] rem_src;
      logic [LANES-1:0][DW-1:0] div_src;
      logic [LANES-1:0][NW-1:0] work_src;
      logic [LANES-1:0][DW:0]   trial;
      logic [LANES-1:0]         ge;
      logic [LANES-1:0][DW-1:0] rem_in;
      logic [LANES-1:0][NW-1:0] work_in;
      logic                     valid_src;
      logic [PW-1:0]            pay_src;

      if (s == 0) begin : g_first
         assign rem_src   = '0;
         assign div_src   = divisor_in;
         assign work_src  = dividend_in;
         assign valid_src = in_valid;
         assign pay_src   = payload_in;
      end else begin : g_next
         assign rem_src   = rem_ff[s-1];
         assign div_src   = div_ff[s-1];
         assign work_src  = work_ff[s-1];
         assign valid_src = valid_ff[s-1];
         assign pay_src   = pay_ff[s-1];
      end

      // The partial remainder stays below the divisor, so the difference fits DW bits.
      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            trial[l]   = {rem_src[l], work_src[l][NW-1]};
            ge[l]      = trial[l] >= {1'b0, div_src[l]};
            rem_in[l]  = ge[l] ? DW'(trial[l] - {1'b0, div_src[l]}) : trial[l][DW-1:0];
            work_in[l] = {work_src[l][NW-2:0], ge[l]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            work_ff[s] <= work_in;
            div_ff[s]  <= div_src;
            pay_ff[s]  <= pay_src;
         end
      end
   end

   assign out_valid   = valid_ff[NW-1];
   assign quotient    = work_ff[NW-1];
   assign payload_out = pay_ff[NW-1];

endmodule
